@@ design/klsr_pkg.sv @@
// klsr_pkg: shared types and constants for the keymap layer stack resolver.
// No dependencies; imported by every module of the block.
`default_nettype none

package klsr_pkg;

  localparam int DEF_NUM_LAYERS  = 8;
  localparam int DEF_NUM_ROWS    = 8;
  localparam int DEF_NUM_COLS    = 16;
  localparam int DEF_STACK_SLOTS = 4;

  localparam int KIND_W  = 3;
  localparam int LAYER_W = 4;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int CODE_W  = 16;
  localparam int COUNT_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [LAYER_W-1:0] CUR_LAYER_RST  = LAYER_W'(1);
  localparam logic [LAYER_W-1:0] BASE_LAYER_RST = LAYER_W'(0);
  localparam logic [CODE_W-1:0]  TRANSPARENT_RST = CODE_W'(1);
  localparam logic [CODE_W-1:0]  NO_KEY_RST      = CODE_W'(0);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP   = 3'd0,
    KIND_SET_BASE = 3'd1,
    KIND_PUSH     = 3'd2,
    KIND_REMOVE   = 3'd3,
    KIND_WRITE    = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANSPARENT = 1'b0,
    CFG_NO_KEY      = 1'b1
  } cfg_reg_t;

  // layer stack update command, one transaction per accepted item
  typedef struct packed {
    logic                en;
    kind_t               kind;
    logic [LAYER_W-1:0]  layer;
  } layer_cmd_t;

endpackage

`default_nettype wire

@@ design/klsr_key_mem.sv @@
// klsr_key_mem: keycode table, one write port and one registered read port.
// Depends on klsr_pkg for the code width.
`default_nettype none

module klsr_key_mem
  import klsr_pkg::*;
#(
  parameter int DEPTH  = DEF_NUM_LAYERS * DEF_NUM_ROWS * DEF_NUM_COLS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CODE_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/klsr_layer_stack.sv @@
// klsr_layer_stack: base layer, current layer and momentary layer stack.
// Depends on klsr_pkg for the command struct and layer constants.
`default_nettype none

module klsr_layer_stack
  import klsr_pkg::*;
#(
  parameter int NUM_LAYERS  = DEF_NUM_LAYERS,
  parameter int STACK_SLOTS = DEF_STACK_SLOTS,
  parameter int CNT_W       = $clog2(STACK_SLOTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire layer_cmd_t         cmd,
  output logic      [LAYER_W-1:0] cur_layer,
  output logic      [LAYER_W-1:0] home_layer,
  output logic      [CNT_W-1:0]   depth
);

  logic [LAYER_W-1:0] slots      [STACK_SLOTS];
  logic [LAYER_W-1:0] slots_next [STACK_SLOTS];
  logic [LAYER_W-1:0] cur_layer_next;
  logic [LAYER_W-1:0] home_layer_next;
  logic [CNT_W-1:0]   depth_next;
  logic               layer_ok;
  logic               hit;
  logic [CNT_W-1:0]   hit_idx;
  logic [LAYER_W-1:0] top_after;

  assign layer_ok = {1'b0, cmd.layer} < (LAYER_W + 1)'(NUM_LAYERS);

  always_comb begin
    slots_next      = slots;
    cur_layer_next  = cur_layer;
    home_layer_next = home_layer;
    depth_next      = depth;
    hit             = 1'b0;
    hit_idx         = '0;
    top_after       = home_layer;

    // topmost matching slot: later matches override earlier ones
    for (int i = 0; i < STACK_SLOTS; i++) begin
      if (CNT_W'(i) < depth && slots[i] == cmd.layer) begin
        hit     = 1'b1;
        hit_idx = CNT_W'(i);
      end
    end

    if (cmd.en) begin
      case (cmd.kind)
        KIND_SET_BASE: begin
          if (layer_ok) begin
            home_layer_next = cmd.layer;
            if (depth == '0) begin
              cur_layer_next = cmd.layer;
            end
          end
        end
        KIND_PUSH: begin
          if (layer_ok && depth < CNT_W'(STACK_SLOTS)) begin
            for (int i = 0; i < STACK_SLOTS; i++) begin
              if (CNT_W'(i) == depth) begin
                slots_next[i] = cmd.layer;
              end
            end
            depth_next     = depth + CNT_W'(1);
            cur_layer_next = cmd.layer;
          end
        end
        KIND_REMOVE: begin
          if (hit) begin
            // close the gap above the removed slot
            for (int i = 0; i < STACK_SLOTS - 1; i++) begin
              if (CNT_W'(i) >= hit_idx) begin
                slots_next[i] = slots[i + 1];
              end
            end
            depth_next = depth - CNT_W'(1);
          end
          for (int i = 0; i < STACK_SLOTS; i++) begin
            if (CNT_W'(i + 1) == depth_next) begin
              top_after = slots_next[i];
            end
          end
          cur_layer_next = (depth_next == '0) ? home_layer : top_after;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_layer  <= CUR_LAYER_RST;
      home_layer <= BASE_LAYER_RST;
      depth      <= '0;
    end else begin
      cur_layer  <= cur_layer_next;
      home_layer <= home_layer_next;
      depth      <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    slots <= slots_next;
  end

endmodule

`default_nettype wire

@@ design/keymap_layer_stack_resolver_top.sv @@
// Keymap layer stack resolver, top level.
// Lookup: ST_CUR registers done from the current-layer read; when the
// transparent code falls back, ST_BASE does so from the base-layer read (one
// table read per cycle, busy meanwhile). Other items and lookups off the key
// matrix give done in the cycle after start, and may be started in every cycle.
// Synchronous reset restores layers and config; table contents are kept.
`default_nettype none

module keymap_layer_stack_resolver_top
  import klsr_pkg::*;
#(
  parameter int NUM_LAYERS  = DEF_NUM_LAYERS,
  parameter int NUM_ROWS    = DEF_NUM_ROWS,
  parameter int NUM_COLS    = DEF_NUM_COLS,
  parameter int STACK_SLOTS = DEF_STACK_SLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic [LAYER_W-1:0]   layer,
  input  wire logic [ROW_W-1:0]     row,
  input  wire logic [COL_W-1:0]     col,
  input  wire logic [CODE_W-1:0]    entry_code,
  output logic                      done,
  output logic      [CODE_W-1:0]    keycode,
  output logic      [LAYER_W-1:0]   active_layer,
  output logic      [COUNT_W-1:0]   stack_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CODE_W-1:0]    cfg_data
);

  localparam int DEPTH    = NUM_LAYERS * NUM_ROWS * NUM_COLS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_SPAN = NUM_ROWS * NUM_COLS;
  localparam int CNT_W    = $clog2(STACK_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_BASE
  } state_t;

  state_t             state;
  logic [CODE_W-1:0]  transparent_code;
  logic [CODE_W-1:0]  no_key_code;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic               accept;
  kind_t              kind_in;
  logic               pos_ok;
  logic               layer_ok;
  logic               fallback;
  layer_cmd_t         cmd;
  logic [LAYER_W-1:0] cur_layer;
  logic [LAYER_W-1:0] home_layer;
  logic [CNT_W-1:0]   depth;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic [CODE_W-1:0]  mem_q;
  logic               mem_we;

  function automatic logic [ADDR_W-1:0] key_addr(
    input logic [LAYER_W-1:0] l,
    input logic [ROW_W-1:0]   r,
    input logic [COL_W-1:0]   c
  );
    return ADDR_W'(ADDR_W'(l) * ADDR_W'(ROW_SPAN) + ADDR_W'(r) * ADDR_W'(NUM_COLS)
                   + ADDR_W'(c));
  endfunction

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign kind_in   = kind_t'(kind);
  assign cfg_ready = 1'b1;

  assign pos_ok   = ({1'b0, row} < (ROW_W + 1)'(NUM_ROWS)) &&
                    ({1'b0, col} < (COL_W + 1)'(NUM_COLS));
  assign layer_ok = {1'b0, layer} < (LAYER_W + 1)'(NUM_LAYERS);
  assign fallback = (mem_q == transparent_code) && (cur_layer != home_layer);

  assign cmd.en    = accept;
  assign cmd.kind  = kind_in;
  assign cmd.layer = layer;

  // second read goes to the base layer with the held key position
  assign raddr  = (state == ST_CUR) ? key_addr(home_layer, row_q, col_q)
                                    : key_addr(cur_layer, row, col);
  assign waddr  = key_addr(layer, row, col);
  assign mem_we = accept && (kind_in == KIND_WRITE) && layer_ok && pos_ok;

  assign active_layer = cur_layer;
  assign stack_count  = COUNT_W'(depth);

  klsr_key_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_key_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (entry_code),
    .raddr (raddr),
    .rdata (mem_q)
  );

  klsr_layer_stack #(
    .NUM_LAYERS  (NUM_LAYERS),
    .STACK_SLOTS (STACK_SLOTS),
    .CNT_W       (CNT_W)
  ) u_layer_stack (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cur_layer  (cur_layer),
    .home_layer (home_layer),
    .depth      (depth)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      transparent_code <= TRANSPARENT_RST;
      no_key_code      <= NO_KEY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TRANSPARENT: transparent_code <= cfg_data;
        CFG_NO_KEY:      no_key_code      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      keycode <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            row_q <= row;
            col_q <= col;
            if (kind_in == KIND_LOOKUP && pos_ok) begin
              state <= ST_CUR;
            end else begin
              done    <= 1'b1;
              keycode <= (kind_in == KIND_LOOKUP) ? no_key_code : '0;
            end
          end
        end
        ST_CUR: begin
          if (fallback) begin
            state <= ST_BASE;
          end else begin
            state   <= ST_IDLE;
            done    <= 1'b1;
            keycode <= mem_q;
          end
        end
        ST_BASE: begin
          state   <= ST_IDLE;
          done    <= 1'b1;
          keycode <= mem_q;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
